// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: concurrent assertion helpers
// clocked, reset-gated property checks reporting through $error
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("property violated");

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: hw/rtl/ctf_pkg.sv
// ----------------------------------------------------------------------------
// ctf_pkg: shared types and constants of the clut texel fetch block
// memory geometry, item beats, mode codes, register indexes, fsm states
// ----------------------------------------------------------------------------
package ctf_pkg;

  // memory geometry, powers of two
  localparam int unsigned MEM_COLS  = 1024;
  localparam int unsigned MEM_ROWS  = 512;
  localparam int unsigned COL_W     = $clog2(MEM_COLS);
  localparam int unsigned ROW_W     = $clog2(MEM_ROWS);
  localparam int unsigned MEM_DEPTH = MEM_COLS * MEM_ROWS;
  localparam int unsigned MEM_AW    = COL_W + ROW_W;
  localparam int unsigned MEM_DW    = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_Y = 1'b1;

  typedef enum logic [1:0] {
    MODE_STORE   = 2'd0,
    MODE_FETCH4  = 2'd1,
    MODE_FETCH8  = 2'd2,
    MODE_FETCH16 = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [9:0]  texel_x;
    logic [8:0]  texel_y;
    logic [9:0]  page_col;
    logic [8:0]  page_row;
    logic [15:0] write_data;
  } ctf_in_t;

  typedef struct packed {
    logic [4:0] red;
    logic [4:0] green;
    logic [4:0] blue;
    logic       mask_bit;
  } ctf_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORD,
    ST_PAL
  } ctf_state_e;

  // controller to datapath
  typedef struct packed {
    logic store;
    logic word_rd;
    logic pal_rd;
    logic out_load;
  } ctf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_store;
    logic item_direct;
  } ctf_sts_t;

  function automatic logic [COL_W-1:0] wrap_col(input logic [10:0] s);
    logic [COL_W+10:0] ext;
    ext = (COL_W+11)'(s);
    return ext[COL_W-1:0];
  endfunction

  function automatic logic [ROW_W-1:0] wrap_row(input logic [9:0] s);
    logic [ROW_W+9:0] ext;
    ext = (ROW_W+10)'(s);
    return ext[ROW_W-1:0];
  endfunction

endpackage

// File: hw/rtl/ctf_ram.sv
// ----------------------------------------------------------------------------
// ctf_ram: generic single-port ram
// one write or one read per cycle, registered read data
// ----------------------------------------------------------------------------
module ctf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ctf_datapath.sv
// ----------------------------------------------------------------------------
// ctf_datapath: address generation, video memory and result register
// builds store, texel word and palette addresses, extracts palette index
// ----------------------------------------------------------------------------
module ctf_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ctf_pkg::ctf_in_t                   in_beat_i,
  input  logic                               cfg_we_i,
  input  logic [ctf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ctf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  ctf_pkg::ctf_cmd_t                  cmd_i,
  output ctf_pkg::ctf_sts_t                  sts_o,
  output logic                               out_valid_o,
  output ctf_pkg::ctf_out_t                  out_beat_o
);
  import ctf_pkg::*;

  logic [9:0]        pal_x_q;
  logic [8:0]        pal_y_q;
  mode_e             mode_q;
  logic [1:0]        sub_q;
  logic              valid_q;
  ctf_out_t          out_q;

  logic [9:0]        col_ofs;
  logic [COL_W-1:0]  st_col, fe_col, pa_col;
  logic [ROW_W-1:0]  st_row, fe_row, pa_row;
  logic [7:0]        pal_idx;
  logic [3:0]        nibble;
  logic [MEM_AW-1:0] ram_addr;
  logic [MEM_DW-1:0] ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_x_q <= '0;
      pal_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PALETTE_X: pal_x_q <= cfg_data_i;
        CFG_PALETTE_Y: pal_y_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.word_rd) begin
      mode_q <= in_beat_i.mode;
      sub_q  <= in_beat_i.texel_x[1:0];
    end
  end

  always_comb begin
    case (in_beat_i.mode)
      MODE_FETCH4: col_ofs = {2'b00, in_beat_i.texel_x[9:2]};
      MODE_FETCH8: col_ofs = {1'b0, in_beat_i.texel_x[9:1]};
      default:     col_ofs = in_beat_i.texel_x;
    endcase
  end

  always_comb begin
    case (sub_q)
      2'd0:    nibble = ram_rdata[3:0];
      2'd1:    nibble = ram_rdata[7:4];
      2'd2:    nibble = ram_rdata[11:8];
      default: nibble = ram_rdata[15:12];
    endcase
    if (mode_q == MODE_FETCH8) begin
      pal_idx = sub_q[0] ? ram_rdata[15:8] : ram_rdata[7:0];
    end else begin
      pal_idx = {4'h0, nibble};
    end
  end

  assign st_col = wrap_col({1'b0, in_beat_i.texel_x});
  assign st_row = wrap_row({1'b0, in_beat_i.texel_y});
  assign fe_col = wrap_col({1'b0, in_beat_i.page_col} + {1'b0, col_ofs});
  assign fe_row = wrap_row({1'b0, in_beat_i.page_row} + {1'b0, in_beat_i.texel_y});
  assign pa_col = wrap_col({1'b0, pal_x_q} + {3'b000, pal_idx});
  assign pa_row = wrap_row({1'b0, pal_y_q});

  always_comb begin
    if (cmd_i.pal_rd) begin
      ram_addr = {pa_row, pa_col};
    end else if (cmd_i.store) begin
      ram_addr = {st_row, st_col};
    end else begin
      ram_addr = {fe_row, fe_col};
    end
  end

  ctf_ram #(
    .WIDTH (MEM_DW),
    .DEPTH (MEM_DEPTH)
  ) u_vram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .addr_i  (ram_addr),
    .wdata_i (in_beat_i.write_data),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.red      <= ram_rdata[4:0];
      out_q.green    <= ram_rdata[9:5];
      out_q.blue     <= ram_rdata[14:10];
      out_q.mask_bit <= ram_rdata[15];
    end
  end

  assign sts_o.in_store    = (in_beat_i.mode == MODE_STORE);
  assign sts_o.item_direct = (mode_q == MODE_FETCH16);
  assign out_valid_o       = valid_q;
  assign out_beat_o        = out_q;

endmodule

// File: hw/rtl/ctf_ctrl.sv
// ----------------------------------------------------------------------------
// ctf_ctrl: sequencer of the clut texel fetch block
// issues store, texel word read, palette read and result load
// ----------------------------------------------------------------------------
module ctf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  ctf_pkg::ctf_sts_t  sts_i,
  output ctf_pkg::ctf_cmd_t  cmd_o,
  output logic               busy
);
  import ctf_pkg::*;

  ctf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (sts_i.in_store) begin
            cmd_o.store = 1'b1;
          end else begin
            cmd_o.word_rd = 1'b1;
            state_d       = ST_WORD;
          end
        end
      end
      ST_WORD: begin
        if (sts_i.item_direct) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          cmd_o.pal_rd = 1'b1;
          state_d      = ST_PAL;
        end
      end
      ST_PAL: begin
        cmd_o.out_load = 1'b1;
        state_d        = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// File: hw/rtl/clut_texel_fetch_top.sv
// ----------------------------------------------------------------------------
// clut_texel_fetch_top: texel fetch over a halfword video memory
// store, 4/8-bit palette and 16-bit direct texel fetches
// ----------------------------------------------------------------------------
// usage
//   in_beat_i is taken at a clock edge with start high and busy low.
//   a store writes write_data at (texel_x, texel_y) and gives no result;
//   busy stays low, so the next beat can follow at once.
//   a 16-bit fetch reads one word, which passes from the memory read
//   register into the result register, raising the strobe. a 4-bit or 8-bit
//   fetch reads the index word, then the palette entry through the same
//   single memory port. busy is high between accept and the result cycle,
//   so no new beat is taken while a fetch is in progress.
//   out_valid_o is high for exactly one cycle with out_beat_o; the
//   receiver cannot stall. a new beat may be accepted in that cycle.
//   palette base registers are written through cfg_we_i, cfg_idx_i and cfg_data_i;
//   the user must do so only while the block is idle, which it does not enforce.
//   reset clears the sequencer, the result strobe and the palette base;
//   video memory holds no defined contents until written.
// ----------------------------------------------------------------------------
module clut_texel_fetch_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  ctf_pkg::ctf_in_t               in_beat_i,
  output logic                           out_valid_o,
  output ctf_pkg::ctf_out_t              out_beat_o,
  input  logic                           cfg_we_i,
  input  logic [ctf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ctf_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ctf_pkg::*;

  ctf_cmd_t cmd;
  ctf_sts_t sts;

  ctf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  ctf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_beat_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o)
  );

endmodule

// File: hw/rtl/ctf_checker.sv
// ----------------------------------------------------------------------------
// ctf_checker: port-level checks of the clut texel fetch block
// relates accepted beats, busy and the result strobe over time
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ctf_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input ctf_pkg::ctf_in_t in_beat_i,
  input logic             out_valid_o
);
  import ctf_pkg::*;

  logic acc_store;
  logic acc_fetch;

  assign acc_store = start && !busy && (in_beat_i.mode == MODE_STORE);
  assign acc_fetch = start && !busy && (in_beat_i.mode != MODE_STORE);

  `ASSERT_PROP(a_store_no_result, clk_i, rst_ni, acc_store |=> !out_valid_o)
  `ASSERT_PROP(a_fetch_goes_busy, clk_i, rst_ni, acc_fetch |=> busy)
  `ASSERT_PROP(a_strobe_single, clk_i, rst_ni, out_valid_o |=> !out_valid_o)
  `ASSERT_NEVER(a_strobe_while_busy, clk_i, rst_ni, out_valid_o && busy)

endmodule

bind clut_texel_fetch_top ctf_checker u_ctf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .in_beat_i   (in_beat_i),
  .out_valid_o (out_valid_o)
);

// File: test/tb_clut_texel_fetch_top.sv
// ----------------------------------------------------------------------------
// tb_clut_texel_fetch_top: self-checking bench for the clut texel fetch block
// a shadow video memory and palette base predict every fetch result; stores
// and fetches are sent in random bursts across several palette base settings
// ----------------------------------------------------------------------------
module tb_clut_texel_fetch_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ctf_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 6;
  localparam int STALL_LIMIT  = 1000;
  localparam int PHASE_BEATS  = 250;
  localparam int NUM_PHASES   = 2;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  start      = 1'b0;
  logic                  busy;
  ctf_in_t               in_beat_i  = '0;
  logic                  out_valid_o;
  ctf_out_t              out_beat_o;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = CFG_PALETTE_X;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic [15:0] vram_shadow [int];
  int          written_q [$];
  int          last_store;
  logic [9:0]  pal_col = '0;
  logic [8:0]  pal_row = '0;
  ctf_out_t    texel_q [$];
  ctf_out_t    want;
  int          burst_left   = 0;
  int          fail_count   = 0;
  int          stall_cycles = 0;

  clut_texel_fetch_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_beat_o (out_beat_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic ctf_in_t mk_beat(input mode_e m, input logic [9:0] tx,
                                      input logic [8:0] ty, input logic [9:0] pc,
                                      input logic [8:0] pr, input logic [15:0] wd);
    ctf_in_t b;
    b.mode       = m;
    b.texel_x    = tx;
    b.texel_y    = ty;
    b.page_col   = pc;
    b.page_row   = pr;
    b.write_data = wd;
    return b;
  endfunction

  // updates the shadow memory on a store, returns 1 with the texel on a fetch
  function automatic bit predict_texel(input ctf_in_t b, output ctf_out_t res);
    logic [9:0]  col;
    logic [8:0]  row;
    logic [15:0] word;
    logic [15:0] shifted;
    logic [7:0]  idx;
    logic [9:0]  pcol;
    logic [15:0] texel;
    int          addr;
    res = '0;
    if (b.mode == MODE_STORE) begin
      addr = int'({b.texel_y, b.texel_x});
      if (!vram_shadow.exists(addr)) written_q.push_back(addr);
      vram_shadow[addr] = b.write_data;
      last_store = addr;
      return 1'b0;
    end
    case (b.mode)
      MODE_FETCH4: col = b.page_col + (b.texel_x >> 2);
      MODE_FETCH8: col = b.page_col + (b.texel_x >> 1);
      default:     col = b.page_col + b.texel_x;
    endcase
    row  = b.page_row + b.texel_y;
    word = vram_shadow[int'({row, col})];
    case (b.mode)
      MODE_FETCH4: begin
        shifted = word >> (b.texel_x[1:0] * 4);
        idx     = {4'h0, shifted[3:0]};
      end
      MODE_FETCH8: begin
        shifted = word >> (b.texel_x[0] * 8);
        idx     = shifted[7:0];
      end
      default: idx = '0;
    endcase
    if (b.mode == MODE_FETCH16) begin
      texel = word;
    end else begin
      pcol  = pal_col + idx;
      texel = vram_shadow[int'({pal_row, pcol})];
    end
    res.red      = texel[4:0];
    res.green    = texel[9:5];
    res.blue     = texel[14:10];
    res.mask_bit = texel[15];
    return 1'b1;
  endfunction

  // fetch with random fields whose word lands on a written entry
  function automatic ctf_in_t random_fetch(input mode_e m);
    ctf_in_t    b;
    int         addr;
    logic [9:0] col_off;
    b.mode       = m;
    b.texel_x    = 10'($urandom_range(0, 1023));
    b.texel_y    = 9'($urandom_range(0, 511));
    b.write_data = 16'($urandom);
    if ($urandom_range(0, 3) == 0) addr = last_store;
    else addr = written_q[$urandom_range(0, written_q.size() - 1)];
    case (m)
      MODE_FETCH4: col_off = b.texel_x >> 2;
      MODE_FETCH8: col_off = b.texel_x >> 1;
      default:     col_off = b.texel_x;
    endcase
    b.page_col = addr[9:0] - col_off;
    b.page_row = addr[18:10] - b.texel_y;
    return b;
  endfunction

  task automatic send_beat(input ctf_in_t b);
    ctf_out_t res;
    int       gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start     <= 1'b1;
    in_beat_i <= b;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    if (predict_texel(b, res)) texel_q.push_back(res);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (texel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_palette_base(input logic [9:0] x, input logic [8:0] y);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PALETTE_X;
    cfg_data_i <= x;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_PALETTE_Y;
    cfg_data_i <= {1'b0, y};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    pal_col    = x;
    pal_row    = y;
    burst_left = 0;
  endtask

  // every index a fetch can produce gets a defined palette entry
  task automatic fill_palette();
    logic [9:0] col;
    for (int i = 0; i < 256; i++) begin
      col = pal_col + 10'(i);
      send_beat(mk_beat(MODE_STORE, col, pal_row, 10'($urandom), 9'($urandom),
                        16'($urandom)));
    end
  endtask

  task automatic test_directed();
    fill_palette();
    send_beat(mk_beat(MODE_STORE,   10'd1023, 9'd511, 10'd0,    9'd0,   16'hFFFF));
    send_beat(mk_beat(MODE_FETCH16, 10'd0,    9'd0,   10'd1023, 9'd511, 16'h0000));
    send_beat(mk_beat(MODE_FETCH16, 10'd1023, 9'd511, 10'd0,    9'd0,   16'h0000));
    send_beat(mk_beat(MODE_FETCH16, 10'd1,    9'd1,   10'd1023, 9'd511, 16'h0000));
    send_beat(mk_beat(MODE_STORE,   10'd5,    9'd7,   10'd1023, 9'd511, 16'h8421));
    send_beat(mk_beat(MODE_FETCH16, 10'd5,    9'd7,   10'd0,    9'd0,   16'hFFFF));
    send_beat(mk_beat(MODE_STORE,   10'd10,   9'd20,  10'd0,    9'd0,   16'hFEDC));
    for (int i = 40; i < 44; i++)
      send_beat(mk_beat(MODE_FETCH4, 10'(i), 9'd20, 10'd0, 9'd0, 16'h0000));
    send_beat(mk_beat(MODE_FETCH8,  10'd20,   9'd20,  10'd0,    9'd0,   16'h0000));
    send_beat(mk_beat(MODE_FETCH8,  10'd21,   9'd20,  10'd0,    9'd0,   16'h0000));
    send_beat(mk_beat(MODE_STORE,   10'd251,  9'd3,   10'd0,    9'd0,   16'h1234));
    send_beat(mk_beat(MODE_FETCH4,  10'd1023, 9'd15,  10'd1020, 9'd500, 16'h0000));
    send_beat(mk_beat(MODE_FETCH8,  10'd1023, 9'd15,  10'd764,  9'd500, 16'h0000));
    send_beat(mk_beat(MODE_FETCH16, 10'd10,   9'd20,  10'd0,    9'd0,   16'h0000));
    send_beat(mk_beat(MODE_STORE,   10'd5,    9'd7,   10'd0,    9'd0,   16'h0000));
    send_beat(mk_beat(MODE_FETCH16, 10'd5,    9'd7,   10'd0,    9'd0,   16'h0000));
  endtask

  // palette base at the far corner, indexes wrap past the last column
  task automatic test_palette_wrap();
    set_palette_base(10'd1023, 9'd511);
    fill_palette();
    send_beat(mk_beat(MODE_STORE,  10'd100, 9'd100, 10'd0, 9'd0, 16'hF0FF));
    send_beat(mk_beat(MODE_FETCH4, 10'd403, 9'd100, 10'd0, 9'd0, 16'h0000));
    send_beat(mk_beat(MODE_FETCH4, 10'd402, 9'd100, 10'd0, 9'd0, 16'h0000));
    send_beat(mk_beat(MODE_FETCH8, 10'd201, 9'd100, 10'd0, 9'd0, 16'h0000));
    send_beat(mk_beat(MODE_FETCH8, 10'd200, 9'd100, 10'd0, 9'd0, 16'h0000));
  endtask

  task automatic test_random_traffic();
    logic [9:0] base_x [NUM_PHASES];
    logic [8:0] base_y [NUM_PHASES];
    logic [9:0] col;
    base_x = '{10'd1023, 10'($urandom)};
    base_y = '{9'd0, 9'($urandom)};
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_palette_base(base_x[p], base_y[p]);
      fill_palette();
      for (int n = 0; n < PHASE_BEATS; n++) begin
        case ($urandom_range(0, 9))
          0, 1: send_beat(mk_beat(MODE_STORE, 10'($urandom), 9'($urandom),
                                  10'($urandom), 9'($urandom), 16'($urandom)));
          2: begin
            col = pal_col + 10'($urandom_range(0, 255));
            send_beat(mk_beat(MODE_STORE, col, pal_row, 10'($urandom), 9'($urandom),
                              16'($urandom)));
          end
          3, 4, 5: send_beat(random_fetch(MODE_FETCH4));
          6, 7:    send_beat(random_fetch(MODE_FETCH8));
          default: send_beat(random_fetch(MODE_FETCH16));
        endcase
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      if (texel_q.size() == 0) begin
        $error("result beat with no fetch pending");
        fail_count++;
      end else begin
        want = texel_q.pop_front();
        if (out_beat_o.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, out_beat_o.red);
          fail_count++;
        end
        if (out_beat_o.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, out_beat_o.green);
          fail_count++;
        end
        if (out_beat_o.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, out_beat_o.blue);
          fail_count++;
        end
        if (out_beat_o.mask_bit !== want.mask_bit) begin
          $error("mask_bit: expected %0d, got %0d", want.mask_bit, out_beat_o.mask_bit);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (start && !busy) || out_valid_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_clut_texel_fetch_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_palette_wrap();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0) begin
      $display("tb_clut_texel_fetch_top: PASS");
    end else begin
      $display("tb_clut_texel_fetch_top: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/ctf_pkg.sv
hw/rtl/ctf_ram.sv
hw/rtl/ctf_datapath.sv
hw/rtl/ctf_ctrl.sv
hw/rtl/clut_texel_fetch_top.sv
hw/rtl/ctf_checker.sv
test/tb_clut_texel_fetch_top.sv
